// ----- design/rfc_pkg.sv -----
// Shared types and constants for the receive frame classifier.
// No dependencies; every other design file refers to this package by scope.
package rfc_pkg;

  // Field widths fixed by the frame format
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  // Result beat: remote_ip, remote_mac, udp_data_length, length_short, padded to bytes
  localparam int unsigned OUT_BITS = IP_W + MAC_W + LEN_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Byte offsets in the frame
  localparam logic [POS_W-1:0] POS_MAC_FIRST   = 6'd6;
  localparam logic [POS_W-1:0] POS_MAC_LAST    = 6'd11;
  localparam logic [POS_W-1:0] POS_TYPE_HI     = 6'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO     = 6'd13;
  localparam logic [POS_W-1:0] POS_VERSION     = 6'd14;
  localparam logic [POS_W-1:0] POS_PROTOCOL    = 6'd23;
  localparam logic [POS_W-1:0] POS_SRC_IP_FIRST = 6'd26;
  localparam logic [POS_W-1:0] POS_SRC_IP_LAST  = 6'd29;
  localparam logic [POS_W-1:0] POS_DST_IP_FIRST = 6'd30;
  localparam logic [POS_W-1:0] POS_DST_IP_LAST  = 6'd33;
  localparam logic [POS_W-1:0] POS_ICMP_TYPE   = 6'd34;
  localparam logic [POS_W-1:0] POS_PORT_HI     = 6'd36;
  localparam logic [POS_W-1:0] POS_PORT_LO     = 6'd37;
  localparam logic [POS_W-1:0] POS_ULEN_HI     = 6'd38;
  localparam logic [POS_W-1:0] POS_ULEN_LO     = 6'd39;
  localparam logic [POS_W-1:0] POS_ARP_TGT_FIRST = 6'd38;
  localparam logic [POS_W-1:0] POS_ARP_TGT_LAST  = 6'd41;
  localparam logic [POS_W-1:0] POS_MAX         = 6'd63;
  // Last byte offset each test needs (frame length minus one)
  localparam logic [POS_W-1:0] POS_NEED_ARP    = 6'd41;
  localparam logic [POS_W-1:0] POS_NEED_ICMP   = 6'd34;
  localparam logic [POS_W-1:0] POS_NEED_UDP    = 6'd39;

  // Protocol codes
  localparam logic [15:0] TYPE_ARP     = 16'h0806;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  VERSION_IHL  = 8'h45;
  localparam logic [LEN_W-1:0] UDP_HDR = 16'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PORT = 1'b1;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_NONE = 2'd0,
    CLASS_ARP  = 2'd1,
    CLASS_ICMP = 2'd2,
    CLASS_UDP  = 2'd3
  } frame_class_t;

  // Header fields gathered while a frame streams in
  typedef struct packed {
    logic [15:0]       ether_type;
    logic [7:0]        version_byte;
    logic [7:0]        ip_protocol;
    logic [7:0]        icmp_kind;
    logic [IP_W-1:0]   ip_destination;
    logic [IP_W-1:0]   arp_target_ip;
    logic [PORT_W-1:0] udp_dest_port;
    logic [LEN_W-1:0]  udp_length_field;
    logic [IP_W-1:0]   source_ip;
    logic [MAC_W-1:0]  source_mac;
  } hdr_t;

  // Completed frame handed to the classifier
  typedef struct packed {
    hdr_t hdr;
    logic long_arp;
    logic long_icmp;
    logic long_udp;
  } frame_snap_t;

endpackage

// ----- design/rfc_capture.sv -----
// Header capture: tracks the byte offset, shifts in header fields and
// latches a snapshot of the frame at its last byte. Depends on rfc_pkg.
module rfc_capture (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         beat_accept,
  input  logic [rfc_pkg::BYTE_W-1:0]   beat_byte,
  input  logic                         beat_last,
  input  logic                         snap_take,
  output logic                         snap_valid,
  output rfc_pkg::frame_snap_t         snap
);

  logic [rfc_pkg::POS_W-1:0] pos;
  logic [rfc_pkg::POS_W-1:0] pos_next;
  rfc_pkg::hdr_t             hdr;
  rfc_pkg::hdr_t             hdr_next;

  // Shift the current byte into whichever field owns this offset
  always_comb begin
    hdr_next = hdr;
    if (pos >= rfc_pkg::POS_MAC_FIRST && pos <= rfc_pkg::POS_MAC_LAST) begin
      hdr_next.source_mac = {hdr.source_mac[rfc_pkg::MAC_W-9:0], beat_byte};
    end
    if (pos == rfc_pkg::POS_TYPE_HI || pos == rfc_pkg::POS_TYPE_LO) begin
      hdr_next.ether_type = {hdr.ether_type[7:0], beat_byte};
    end
    if (pos == rfc_pkg::POS_VERSION) begin
      hdr_next.version_byte = beat_byte;
    end
    if (pos == rfc_pkg::POS_PROTOCOL) begin
      hdr_next.ip_protocol = beat_byte;
    end
    if (pos >= rfc_pkg::POS_SRC_IP_FIRST && pos <= rfc_pkg::POS_SRC_IP_LAST) begin
      hdr_next.source_ip = {hdr.source_ip[rfc_pkg::IP_W-9:0], beat_byte};
    end
    if (pos >= rfc_pkg::POS_DST_IP_FIRST && pos <= rfc_pkg::POS_DST_IP_LAST) begin
      hdr_next.ip_destination = {hdr.ip_destination[rfc_pkg::IP_W-9:0], beat_byte};
    end
    if (pos == rfc_pkg::POS_ICMP_TYPE) begin
      hdr_next.icmp_kind = beat_byte;
    end
    if (pos == rfc_pkg::POS_PORT_HI || pos == rfc_pkg::POS_PORT_LO) begin
      hdr_next.udp_dest_port = {hdr.udp_dest_port[7:0], beat_byte};
    end
    if (pos == rfc_pkg::POS_ULEN_HI || pos == rfc_pkg::POS_ULEN_LO) begin
      hdr_next.udp_length_field = {hdr.udp_length_field[7:0], beat_byte};
    end
    if (pos >= rfc_pkg::POS_ARP_TGT_FIRST && pos <= rfc_pkg::POS_ARP_TGT_LAST) begin
      hdr_next.arp_target_ip = {hdr.arp_target_ip[rfc_pkg::IP_W-9:0], beat_byte};
    end
  end

  // Advance the offset, holding at the top
  always_comb begin
    pos_next = pos;
    if (pos != rfc_pkg::POS_MAX) begin
      pos_next = pos + 1'b1;
    end
  end

  // Capture registers clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      hdr <= '0;
    end else if (beat_accept) begin
      if (beat_last) begin
        pos <= '0;
        hdr <= '0;
      end else begin
        pos <= pos_next;
        hdr <= hdr_next;
      end
    end
  end

  // Snapshot slot: filled by a last beat, drained by the classifier
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (beat_accept && beat_last) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_accept && beat_last) begin
      snap.hdr       <= hdr_next;
      snap.long_arp  <= (pos >= rfc_pkg::POS_NEED_ARP);
      snap.long_icmp <= (pos >= rfc_pkg::POS_NEED_ICMP);
      snap.long_udp  <= (pos >= rfc_pkg::POS_NEED_UDP);
    end
  end

endmodule

// ----- design/rfc_classify.sv -----
// Frame classification and result register: decides the class of a
// completed frame and holds the result beat. Depends on rfc_pkg.
module rfc_classify (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          snap_valid,
  input  rfc_pkg::frame_snap_t          snap,
  input  logic [rfc_pkg::IP_W-1:0]      local_ip,
  input  logic [rfc_pkg::PORT_W-1:0]    local_port,
  input  logic                          res_ready,
  output logic                          snap_take,
  output logic                          res_valid,
  output rfc_pkg::frame_class_t         frame_class,
  output logic [rfc_pkg::IP_W-1:0]      remote_ip,
  output logic [rfc_pkg::MAC_W-1:0]     remote_mac,
  output logic [rfc_pkg::LEN_W-1:0]     udp_data_length,
  output logic                          length_short
);

  rfc_pkg::frame_class_t      cls;
  logic                       is_short;
  logic [rfc_pkg::LEN_W-1:0]  payload_len;
  logic                       res_free;

  // Decide the class from the full ethertype and header fields
  always_comb begin
    cls = rfc_pkg::CLASS_NONE;
    if (snap.hdr.ether_type == rfc_pkg::TYPE_ARP) begin
      if (snap.long_arp && snap.hdr.arp_target_ip == local_ip) begin
        cls = rfc_pkg::CLASS_ARP;
      end
    end else if (snap.hdr.ether_type == rfc_pkg::TYPE_IPV4) begin
      if (snap.hdr.version_byte == rfc_pkg::VERSION_IHL &&
          snap.hdr.ip_destination == local_ip) begin
        if (snap.hdr.ip_protocol == rfc_pkg::PROTO_ICMP &&
            snap.hdr.icmp_kind == rfc_pkg::ECHO_REQUEST) begin
          if (snap.long_icmp) begin
            cls = rfc_pkg::CLASS_ICMP;
          end
        end else if (snap.hdr.ip_protocol == rfc_pkg::PROTO_UDP &&
                     snap.hdr.udp_dest_port == local_port) begin
          if (snap.long_udp) begin
            cls = rfc_pkg::CLASS_UDP;
          end
        end
      end
    end
  end

  // Strip the UDP header length, floored at zero
  assign is_short = (snap.hdr.udp_length_field < rfc_pkg::UDP_HDR);
  assign payload_len = is_short ? '0 : (snap.hdr.udp_length_field - rfc_pkg::UDP_HDR);

  assign res_free  = !res_valid || res_ready;
  assign snap_take = snap_valid && res_free;

  // Result register: refill whenever the current beat is gone
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      frame_class     <= cls;
      remote_ip       <= snap.hdr.source_ip;
      remote_mac      <= snap.hdr.source_mac;
      udp_data_length <= payload_len;
      length_short    <= is_short;
    end
  end

endmodule

// ----- design/receive_frame_classifier.sv -----
// Top level of the receive frame classifier: configuration registers,
// header capture and classification. Depends on rfc_pkg, rfc_capture, rfc_classify.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata frame_byte, s_tlast frame_last
//  m_      | out | m_tvalid/m_tready | m_tuser frame_class, m_tdata result fields
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// One frame byte is taken per cycle while s_tready is high. A frame's last byte
// is registered in the snapshot register, which holds the frame while the
// classification compare feeds the result register that drives m_tvalid.
// Reset (rst, synchronous) clears the byte offset, all captured fields and
// both configuration registers. s_tready drops only while a finished frame
// waits in the snapshot register behind a stalled result beat.
module receive_frame_classifier (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rfc_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] frame_byte
  input  logic                               s_tlast,  // frame_last
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] remote_ip, [79:32] remote_mac, [95:80] udp_data_length,
  // [96] length_short, [103:97] zero
  output logic [rfc_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [rfc_pkg::CLASS_W-1:0]        m_tuser,  // [1:0] frame_class
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [rfc_pkg::IP_W-1:0]   local_ip;
  logic [rfc_pkg::PORT_W-1:0] local_port;
  logic                       beat_accept;
  logic                       snap_valid;
  logic                       snap_take;
  rfc_pkg::frame_snap_t       snap;
  rfc_pkg::frame_class_t      frame_class;
  logic [rfc_pkg::IP_W-1:0]   remote_ip;
  logic [rfc_pkg::MAC_W-1:0]  remote_mac;
  logic [rfc_pkg::LEN_W-1:0]  udp_data_length;
  logic                       length_short;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip   <= '0;
      local_port <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rfc_pkg::REG_LOCAL_IP:   local_ip   <= cfg_data;
        rfc_pkg::REG_LOCAL_PORT: local_port <= cfg_data[rfc_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall input only when the snapshot slot cannot drain
  assign s_tready    = !snap_valid || snap_take;
  assign beat_accept = s_tvalid && s_tready;

  rfc_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .beat_accept (beat_accept),
    .beat_byte   (s_tdata),
    .beat_last   (s_tlast),
    .snap_take   (snap_take),
    .snap_valid  (snap_valid),
    .snap        (snap)
  );

  rfc_classify u_classify (
    .clk             (clk),
    .rst             (rst),
    .snap_valid      (snap_valid),
    .snap            (snap),
    .local_ip        (local_ip),
    .local_port      (local_port),
    .res_ready       (m_tready),
    .snap_take       (snap_take),
    .res_valid       (m_tvalid),
    .frame_class     (frame_class),
    .remote_ip       (remote_ip),
    .remote_mac      (remote_mac),
    .udp_data_length (udp_data_length),
    .length_short    (length_short)
  );

  // Pack the result beat
  assign m_tuser = frame_class;
  assign m_tdata = {{(rfc_pkg::OUT_DATA_W - rfc_pkg::OUT_BITS){1'b0}},
                    length_short, udp_data_length, remote_mac, remote_ip};

`ifndef NO_ASSERTIONS
  // A taken last byte always lands in the snapshot slot
  a_last_fills_snap: assert property (@(posedge clk) disable iff (rst)
    beat_accept && s_tlast |=> snap_valid)
    else $error("last byte did not fill snapshot");

  // A waiting snapshot with a free result register becomes a result beat
  a_snap_to_result: assert property (@(posedge clk) disable iff (rst)
    snap_valid && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("snapshot did not move to result register");

  // A short UDP length field always yields a zero data length
  a_short_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && length_short |-> udp_data_length == '0)
    else $error("short length with nonzero data length");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for receive_frame_classifier: streams Ethernet frames
// byte by byte and checks every class/result beat against a built-in predictor.
// Depends on rfc_pkg and the receive_frame_classifier RTL only.
module testbench;
  import rfc_pkg::*;

  // Expected or observed result beat
  typedef struct packed {
    frame_class_t          cls;
    logic [IP_W-1:0]       remote_ip;
    logic [MAC_W-1:0]      remote_mac;
    logic [LEN_W-1:0]      payload_len;
    logic                  length_short;
  } result_t;

  typedef enum int {MAKE_ARP, MAKE_ICMP, MAKE_UDP, MAKE_NOISE} frame_kind_t;

  // Header capture and classification predictor plus the queue of pending results
  class frame_scoreboard;
    logic [IP_W-1:0]   own_ip;
    logic [PORT_W-1:0] own_port;
    logic [POS_W-1:0]  offset;
    logic [15:0]       etype;
    logic [7:0]        version;
    logic [7:0]        proto;
    logic [7:0]        icmp_type;
    logic [IP_W-1:0]   dst_ip;
    logic [IP_W-1:0]   arp_ip;
    logic [PORT_W-1:0] dst_port;
    logic [LEN_W-1:0]  ulen;
    logic [IP_W-1:0]   src_ip;
    logic [MAC_W-1:0]  src_mac;
    result_t           pending_q[$];

    function new();
      own_ip = '0;
      own_port = '0;
      clear_capture();
    endfunction

    function void clear_capture();
      offset = '0;
      etype = '0;
      version = '0;
      proto = '0;
      icmp_type = '0;
      dst_ip = '0;
      arp_ip = '0;
      dst_port = '0;
      ulen = '0;
      src_ip = '0;
      src_mac = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_LOCAL_IP) begin
        own_ip = val[IP_W-1:0];
      end else if (idx == REG_LOCAL_PORT) begin
        own_port = val[PORT_W-1:0];
      end
    endfunction

    // Capture one accepted frame byte; on the last byte queue the expected result
    function void note_beat(logic [7:0] b, logic last);
      logic [POS_W-1:0] at;
      frame_class_t cls;
      result_t r;
      at = offset;
      cls = CLASS_NONE;
      if (at >= POS_MAC_FIRST && at <= POS_MAC_LAST) src_mac = {src_mac[MAC_W-9:0], b};
      if (at == POS_TYPE_HI || at == POS_TYPE_LO) etype = {etype[7:0], b};
      if (at == POS_VERSION) version = b;
      if (at == POS_PROTOCOL) proto = b;
      if (at >= POS_SRC_IP_FIRST && at <= POS_SRC_IP_LAST) src_ip = {src_ip[23:0], b};
      if (at >= POS_DST_IP_FIRST && at <= POS_DST_IP_LAST) dst_ip = {dst_ip[23:0], b};
      if (at == POS_ICMP_TYPE) icmp_type = b;
      if (at == POS_PORT_HI || at == POS_PORT_LO) dst_port = {dst_port[7:0], b};
      if (at == POS_ULEN_HI || at == POS_ULEN_LO) ulen = {ulen[7:0], b};
      if (at >= POS_ARP_TGT_FIRST && at <= POS_ARP_TGT_LAST) arp_ip = {arp_ip[23:0], b};
      if (at < POS_MAX) offset = at + 1'b1;
      if (!last) return;

      if (etype == TYPE_ARP) begin
        if (at >= POS_NEED_ARP && arp_ip == own_ip) cls = CLASS_ARP;
      end else if (etype == TYPE_IPV4) begin
        if (version == VERSION_IHL && dst_ip == own_ip) begin
          if (proto == PROTO_ICMP && icmp_type == ECHO_REQUEST) begin
            if (at >= POS_NEED_ICMP) cls = CLASS_ICMP;
          end else if (proto == PROTO_UDP && dst_port == own_port) begin
            if (at >= POS_NEED_UDP) cls = CLASS_UDP;
          end
        end
      end
      r.cls = cls;
      r.remote_ip = src_ip;
      r.remote_mac = src_mac;
      r.length_short = (ulen < UDP_HDR);
      r.payload_len = r.length_short ? '0 : ulen - UDP_HDR;
      pending_q.push_back(r);
      clear_capture();
    endfunction

    // Compare one result beat with the oldest expectation; empty string means match
    function string check_result(result_t got);
      result_t want;
      string msg;
      msg = "";
      if (pending_q.size() == 0) return "result beat with no frame pending";
      want = pending_q.pop_front();
      if (got.cls !== want.cls)
        msg = {msg, $sformatf(" class %0d/%0d", got.cls, want.cls)};
      if (got.remote_ip !== want.remote_ip)
        msg = {msg, $sformatf(" ip %h/%h", got.remote_ip, want.remote_ip)};
      if (got.remote_mac !== want.remote_mac)
        msg = {msg, $sformatf(" mac %h/%h", got.remote_mac, want.remote_mac)};
      if (got.payload_len !== want.payload_len)
        msg = {msg, $sformatf(" len %0d/%0d", got.payload_len, want.payload_len)};
      if (got.length_short !== want.length_short)
        msg = {msg, $sformatf(" short %b/%b", got.length_short, want.length_short)};
      if (msg != "") msg = {"frame result (got/expected):", msg};
      return msg;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [CLASS_W-1:0]    m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb;
  int errors = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_cycles = 0;

  receive_frame_classifier DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  task report(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Watch both streams: note accepted bytes, check accepted result beats
  always @(posedge clk) begin
    result_t got;
    string msg;
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_beat(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.cls = frame_class_t'(m_tuser);
        got.remote_ip = m_tdata[31:0];
        got.remote_mac = m_tdata[79:32];
        got.payload_len = m_tdata[95:80];
        got.length_short = m_tdata[96];
        msg = sb.check_result(got);
        if (msg != "") report(msg);
      end
    end
  end

  // Drive result-side ready: random stalls, or a counted hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold until taken
  task send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_frame(input logic [7:0] f[$]);
    foreach (f[i]) send_beat(f[i], i == f.size() - 1);
  endtask

  // Write both registers; keep valid high across the pair
  task set_config(input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port);
    logic [CFG_DATA_W-1:0] port_word;
    port_word = {16'($urandom_range(16'hFFFF)), port};
    cfg_valid <= 1'b1;
    cfg_index <= REG_LOCAL_IP;
    cfg_data <= ip;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(REG_LOCAL_IP, ip);
    cfg_index <= REG_LOCAL_PORT;
    cfg_data <= port_word;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(REG_LOCAL_PORT, port_word);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait for every pending result, then let the pipeline settle
  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write a big-endian field into the frame, dropping bytes past its end
  function automatic void put_field(ref logic [7:0] f[$], input int off,
                                    input logic [47:0] val, input int nbytes);
    for (int i = 0; i < nbytes; i++)
      if (off + i < f.size()) f[off + i] = 8'(val >> (8 * (nbytes - 1 - i)));
  endfunction

  function automatic int need_len(frame_kind_t k);
    case (k)
      MAKE_ARP:  return POS_NEED_ARP + 1;
      MAKE_ICMP: return POS_NEED_ICMP + 1;
      MAKE_UDP:  return POS_NEED_UDP + 1;
      default:   return 1;
    endcase
  endfunction

  // Fill a frame with random bytes, then lay in the headers for its kind
  function automatic void build_frame(ref logic [7:0] f[$], input frame_kind_t k,
                                      input int len, input bit clean);
    logic [LEN_W-1:0] udp_len;
    int spots[$];
    f.delete();
    for (int i = 0; i < len; i++) f.push_back(8'($urandom_range(255)));
    case ($urandom_range(3))
      0:       udp_len = 16'($urandom_range(7));
      1:       udp_len = UDP_HDR;
      2:       udp_len = 16'hFFFF;
      default: udp_len = 16'($urandom_range(16'hFFFF));
    endcase
    case (k)
      MAKE_ARP: begin
        put_field(f, POS_TYPE_HI, TYPE_ARP, 2);
        put_field(f, POS_ARP_TGT_FIRST, sb.own_ip, 4);
      end
      MAKE_ICMP: begin
        put_field(f, POS_TYPE_HI, TYPE_IPV4, 2);
        put_field(f, POS_VERSION, VERSION_IHL, 1);
        put_field(f, POS_PROTOCOL, PROTO_ICMP, 1);
        put_field(f, POS_DST_IP_FIRST, sb.own_ip, 4);
        put_field(f, POS_ICMP_TYPE, ECHO_REQUEST, 1);
      end
      MAKE_UDP: begin
        put_field(f, POS_TYPE_HI, TYPE_IPV4, 2);
        put_field(f, POS_VERSION, VERSION_IHL, 1);
        put_field(f, POS_PROTOCOL, PROTO_UDP, 1);
        put_field(f, POS_DST_IP_FIRST, sb.own_ip, 4);
        put_field(f, POS_PORT_HI, sb.own_port, 2);
        put_field(f, POS_ULEN_HI, udp_len, 2);
      end
      default: ;
    endcase
    // Break one header byte that a test looks at
    if (!clean) begin
      spots = '{12, 13, 14, 23, 30, 31, 32, 33, 34, 36, 37, 38, 39, 40, 41};
      put_field(f, spots[$urandom_range(spots.size() - 1)], $urandom_range(255), 1);
    end
  endfunction

  // Boundary frames: exact minimum lengths, one short, odd headers, extreme bytes
  task automatic run_directed();
    logic [7:0] f[$];
    build_frame(f, MAKE_ARP, 42, 1);
    put_field(f, POS_MAC_FIRST, 48'hFFFF_FFFF_FFFF, 6);
    send_frame(f);
    build_frame(f, MAKE_ARP, 41, 1);
    send_frame(f);
    build_frame(f, MAKE_ICMP, 35, 1);
    put_field(f, POS_SRC_IP_FIRST, 32'hFFFF_FFFF, 4);
    send_frame(f);
    build_frame(f, MAKE_ICMP, 34, 1);
    send_frame(f);
    build_frame(f, MAKE_UDP, 40, 1);
    put_field(f, POS_ULEN_HI, UDP_HDR, 2);
    put_field(f, POS_MAC_FIRST, 48'h0, 6);
    send_frame(f);
    build_frame(f, MAKE_UDP, 39, 1);
    send_frame(f);
    build_frame(f, MAKE_UDP, 44, 1);
    put_field(f, POS_ULEN_HI, 16'h0000, 2);
    send_frame(f);
    build_frame(f, MAKE_UDP, 41, 1);
    put_field(f, POS_ULEN_HI, UDP_HDR - 1'b1, 2);
    send_frame(f);
    // Long frame: offset saturates, trailing bytes ignored
    build_frame(f, MAKE_UDP, 70, 1);
    put_field(f, POS_ULEN_HI, 16'hFFFF, 2);
    send_frame(f);
    // Ethertype whose low byte alone matches ARP
    build_frame(f, MAKE_ARP, 42, 1);
    put_field(f, POS_TYPE_HI, 16'h0006, 2);
    send_frame(f);
    build_frame(f, MAKE_ICMP, 40, 1);
    put_field(f, POS_VERSION, 8'h46, 1);
    send_frame(f);
    build_frame(f, MAKE_ICMP, 40, 1);
    put_field(f, POS_ICMP_TYPE, 8'h00, 1);
    send_frame(f);
    build_frame(f, MAKE_UDP, 40, 1);
    put_field(f, POS_PROTOCOL, 8'h06, 1);
    send_frame(f);
    build_frame(f, MAKE_UDP, 40, 1);
    put_field(f, POS_PORT_HI, ~sb.own_port, 2);
    send_frame(f);
    build_frame(f, MAKE_ICMP, 40, 1);
    put_field(f, POS_DST_IP_FIRST, ~sb.own_ip, 4);
    send_frame(f);
    build_frame(f, MAKE_NOISE, 1, 1);
    send_frame(f);
    f.delete();
    repeat (20) f.push_back(8'h00);
    send_frame(f);
    f.delete();
    repeat (64) f.push_back(8'hFF);
    send_frame(f);
  endtask

  // Mostly well-formed frames with random content, plus broken, cut and noise frames
  task automatic run_random(input int byte_goal, input int frame_goal);
    logic [7:0] f[$];
    int sent_bytes;
    int frames;
    int pick;
    int len;
    bit clean;
    frame_kind_t k;
    sent_bytes = 0;
    frames = 0;
    while (sent_bytes < byte_goal || frames < frame_goal) begin
      pick = $urandom_range(99);
      k = frame_kind_t'($urandom_range(2));
      clean = 1'b1;
      len = need_len(k) + (($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(4));
      if (pick >= 70 && pick < 85) begin
        clean = 1'b0;
      end else if (pick >= 85 && pick < 95) begin
        len = $urandom_range(need_len(k) - 1, 1);
      end else if (pick >= 95) begin
        k = MAKE_NOISE;
        len = $urandom_range(72, 1);
      end
      build_frame(f, k, len, clean);
      send_frame(f);
      sent_bytes += len;
      frames++;
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(32'hC0A8_0164, 16'h1F90);
    run_directed();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          set_config(32'hFFFF_FFFF, 16'hFFFF);
          // Long receiver hold-off while bytes keep coming
          hold_cycles = 400;
        end
        1: begin
          src_idle_pct = 57;
          sink_stall_pct = 0;
          set_config(32'h0000_0000, 16'h0000);
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 57;
          set_config($urandom, 16'($urandom_range(16'hFFFF)));
        end
        default: begin
          src_idle_pct = 27;
          sink_stall_pct = 27;
          set_config($urandom, 16'($urandom_range(16'hFFFF)));
        end
      endcase
      run_random(150, 3);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
